>>> design/srm_pkg.sv
// shared types and constants for the shortest removal block
// used by srm_resid and the top level, no dependencies
package srm_pkg;

    localparam int VAL_W = 32;
    localparam int MOD_W = 31;
    localparam int LEN_W = 10;
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } in_t;

    typedef struct packed {
        logic             found;
        logic [LEN_W-1:0] removal_length;
        logic             overflow;
    } out_t;

endpackage

>>> design/srm_resid.sv
// iterative residue unit: signed value reduced to [0, modulus), one bit per cycle
// depends on srm_pkg
module srm_resid (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [srm_pkg::VAL_W-1:0]    value,
    input  logic [srm_pkg::MOD_W-1:0]           modulus,
    output logic                                done,
    output logic [srm_pkg::MOD_W-1:0]           residue
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [5:0]                  cnt_reg, cnt_next;
    logic [srm_pkg::VAL_W-1:0]   dvd_reg, dvd_next;
    logic [srm_pkg::VAL_W-1:0]   rem_reg, rem_next;
    logic                        neg_reg, neg_next;
    logic [srm_pkg::MOD_W-1:0]   res_reg, res_next;
    logic [srm_pkg::VAL_W-1:0]   rem_sh;
    logic [srm_pkg::VAL_W-1:0]   mod_ext;

    assign mod_ext = {1'b0, modulus};
    assign rem_sh  = {rem_reg[srm_pkg::VAL_W-2:0], dvd_reg[srm_pkg::VAL_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            neg_next  = value[srm_pkg::VAL_W-1];
            dvd_next  = value[srm_pkg::VAL_W-1] ? (~value + 32'sd1) : value;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg && (rem_reg[srm_pkg::MOD_W-1:0] != '0)) begin
                    res_next = modulus - rem_reg[srm_pkg::MOD_W-1:0];
                end else begin
                    res_next = rem_reg[srm_pkg::MOD_W-1:0];
                end
            end else begin
                cnt_next = cnt_reg - 6'd1;
                dvd_next = {dvd_reg[srm_pkg::VAL_W-2:0], 1'b0};
                rem_next = (rem_sh >= mod_ext) ? (rem_sh - mod_ext) : rem_sh;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done    = done_reg;
    assign residue = res_reg;

endmodule

>>> design/srm_tab.sv
// residue hash table memory: valid, key and position per slot
// one write and one registered read port, no dependencies
module srm_tab #(
    parameter int SLOTS = 4096,
    parameter int DW    = 43
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(SLOTS)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(SLOTS)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);

    logic [DW-1:0] mem [SLOTS];
    logic [DW-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    assign rd_data = q_reg;

endmodule

>>> design/shortest_removal_mod_divisible.sv
// top level: element store, residue pass, hash table scan and apb register
// uses srm_pkg, srm_resid and srm_tab
// sequence: after the last request, a residue pass over the stored elements, then if the total
// is nonzero a pass clearing every table slot and a hash probe and insert per element
// throughput: one request per cycle in S_LOAD unless last and m_valid; one set at a time
// reset: synchronous active low, modulus returns to 1 and the set count to zero
module shortest_removal_mod_divisible #(
    parameter int MAX_ITEMS   = 1024,
    parameter int TABLE_SLOTS = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  srm_pkg::in_t         s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output srm_pkg::out_t        m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int BW = $clog2(MAX_ITEMS + 2);
    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int NW = SW + 1;
    localparam int MW = srm_pkg::MOD_W;
    localparam int TW = 1 + MW + CW;
    localparam logic [SW-1:0] HMULT_LO = srm_pkg::HASH_MULT[SW-1:0];

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_RRD   = 4'd1;
    localparam logic [3:0] S_RDIV  = 4'd2;
    localparam logic [3:0] S_RWAIT = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_CLR   = 4'd5;
    localparam logic [3:0] S_HASH  = 4'd6;
    localparam logic [3:0] S_PRD   = 4'd7;
    localparam logic [3:0] S_PCHK  = 4'd8;
    localparam logic [3:0] S_SRD   = 4'd9;
    localparam logic [3:0] S_SCALC = 4'd10;
    localparam logic [3:0] S_NEED  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]             state_reg, state_next;
    logic [MW-1:0]          mod_reg;
    logic [MW-1:0]          m_eff;
    logic [CW-1:0]          count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [srm_pkg::VAL_W-1:0] total_reg, total_next;
    logic [srm_pkg::VAL_W-1:0] prefix_reg, prefix_next;
    logic [MW-1:0]          key_reg, key_next;
    logic                   put_reg, put_next;
    logic [SW-1:0]          slot_reg, slot_next;
    logic [NW-1:0]          probe_reg, probe_next;
    logic [BW-1:0]          best_reg, best_next;
    logic                   mval_reg, mval_next;
    srm_pkg::out_t          mdat_reg, mdat_next;

    logic [srm_pkg::VAL_W-1:0] store [MAX_ITEMS];
    logic [srm_pkg::VAL_W-1:0] elem_q;
    logic                      el_rd;
    logic [AW-1:0]             el_raddr;
    logic                      el_wr;
    logic [AW-1:0]             el_waddr;
    logic [srm_pkg::VAL_W-1:0] el_wdata;

    logic              div_start, div_done;
    logic [MW-1:0]     div_res;
    logic              tb_rd, tb_wr;
    logic [SW-1:0]     tb_waddr;
    logic [TW-1:0]     tb_q, tb_wdata;
    logic              tb_valid;
    logic [MW-1:0]     tb_key;
    logic [CW-1:0]     tb_pos;
    logic [2*SW-1:0]   hprod;
    logic              s_acc;
    logic [srm_pkg::VAL_W-1:0] sum_tmp;
    logic [CW-1:0]     hit_len;
    logic [srm_pkg::VAL_W-1:0] mod_ext;

    assign m_eff   = (mod_reg == '0) ? {{(MW-1){1'b0}}, 1'b1} : mod_reg;
    assign mod_ext = {1'b0, m_eff};
    assign s_ready = (state_reg == S_LOAD) && (!s_data.last || !mval_reg);
    assign s_acc   = s_valid && s_ready;
    assign {tb_valid, tb_key, tb_pos} = tb_q;
    assign hprod   = key_reg[SW-1:0] * HMULT_LO;
    assign hit_len = idx_reg - tb_pos;

    // apb register
    assign pready = 1'b1;
    assign prdata = {1'b0, mod_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= {{(MW-1){1'b0}}, 1'b1};
        end else if (psel && penable && pwrite && (paddr[1:0] == 2'd0)) begin
            mod_reg <= pwdata[MW-1:0];
        end
    end

    // element store
    always_ff @(posedge aclk) begin
        if (el_wr) begin
            store[el_waddr] <= el_wdata;
        end
        if (el_rd) begin
            elem_q <= store[el_raddr];
        end
    end

    srm_resid u_resid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .value   (elem_q),
        .modulus (m_eff),
        .done    (div_done),
        .residue (div_res)
    );

    srm_tab #(
        .SLOTS (TABLE_SLOTS),
        .DW    (TW)
    ) u_tab (
        .aclk    (aclk),
        .rd_en   (tb_rd),
        .rd_addr (slot_reg),
        .rd_data (tb_q),
        .wr_en   (tb_wr),
        .wr_addr (tb_waddr),
        .wr_data (tb_wdata)
    );

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        total_next  = total_reg;
        prefix_next = prefix_reg;
        key_next    = key_reg;
        put_next    = put_reg;
        slot_next   = slot_reg;
        probe_next  = probe_reg;
        best_next   = best_reg;
        mval_next   = mval_reg;
        mdat_next   = mdat_reg;
        el_rd       = 1'b0;
        el_raddr    = idx_reg[AW-1:0];
        el_wr       = 1'b0;
        el_waddr    = idx_reg[AW-1:0];
        el_wdata    = {1'b0, div_res};
        div_start   = 1'b0;
        tb_rd       = 1'b0;
        tb_wr       = 1'b0;
        tb_waddr    = slot_reg;
        tb_wdata    = {1'b1, key_reg, idx_reg};
        sum_tmp     = '0;

        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD: begin
                if (s_acc) begin
                    if (count_reg < CW'(MAX_ITEMS)) begin
                        el_wr      = 1'b1;
                        el_waddr   = count_reg[AW-1:0];
                        el_wdata   = s_data.value;
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_data.last) begin
                        if (ovf_reg || (count_reg == CW'(MAX_ITEMS))) begin
                            mval_next  = 1'b1;
                            mdat_next  = '{found: 1'b0, removal_length: '0, overflow: 1'b1};
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end else begin
                            idx_next   = '0;
                            total_next = '0;
                            state_next = S_RRD;
                        end
                    end
                end
            end
            S_RRD: begin
                el_rd      = 1'b1;
                state_next = S_RDIV;
            end
            S_RDIV: begin
                div_start  = 1'b1;
                state_next = S_RWAIT;
            end
            S_RWAIT: begin
                if (div_done) begin
                    el_wr      = 1'b1;
                    sum_tmp    = total_reg + {1'b0, div_res};
                    total_next = (sum_tmp >= mod_ext) ? (sum_tmp - mod_ext) : sum_tmp;
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_reg + 1'b1 == count_reg) ? S_CHECK : S_RRD;
                end
            end
            S_CHECK: begin
                if (total_reg == '0) begin
                    mval_next  = 1'b1;
                    mdat_next  = '{found: 1'b1, removal_length: '0, overflow: 1'b0};
                    count_next = '0;
                    state_next = S_LOAD;
                end else begin
                    slot_next  = '0;
                    state_next = S_CLR;
                end
            end
            S_CLR: begin
                tb_wr    = 1'b1;
                tb_wdata = '0;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == {SW{1'b1}}) begin
                    key_next    = '0;
                    prefix_next = '0;
                    idx_next    = '0;
                    put_next    = 1'b1;
                    best_next   = BW'(count_reg) + 1'b1;
                    state_next  = S_HASH;
                end
            end
            S_HASH: begin
                slot_next  = hprod[SW-1:0];
                probe_next = '0;
                state_next = S_PRD;
            end
            S_PRD: begin
                tb_rd      = 1'b1;
                state_next = S_PCHK;
            end
            S_PCHK: begin
                slot_next  = slot_reg + 1'b1;
                probe_next = probe_reg + 1'b1;
                if (!put_reg) begin
                    if (!tb_valid || (tb_key == key_reg)
                            || (probe_reg + 1'b1 == NW'(TABLE_SLOTS))) begin
                        if (tb_valid && (tb_key == key_reg) && (BW'(hit_len) < best_reg)) begin
                            best_next = BW'(hit_len);
                        end
                        key_next   = prefix_reg[MW-1:0];
                        put_next   = 1'b1;
                        state_next = S_HASH;
                    end else begin
                        state_next = S_PRD;
                    end
                end else begin
                    if (!tb_valid || (tb_key == key_reg)
                            || (probe_reg + 1'b1 == NW'(TABLE_SLOTS))) begin
                        tb_wr      = !tb_valid || (tb_key == key_reg);
                        state_next = (idx_reg == count_reg) ? S_DONE : S_SRD;
                    end else begin
                        state_next = S_PRD;
                    end
                end
            end
            S_SRD: begin
                el_rd      = 1'b1;
                state_next = S_SCALC;
            end
            S_SCALC: begin
                sum_tmp     = prefix_reg + elem_q;
                prefix_next = (sum_tmp >= mod_ext) ? (sum_tmp - mod_ext) : sum_tmp;
                idx_next    = idx_reg + 1'b1;
                state_next  = S_NEED;
            end
            S_NEED: begin
                if (prefix_reg >= total_reg) begin
                    sum_tmp = prefix_reg - total_reg;
                end else begin
                    sum_tmp = prefix_reg + mod_ext - total_reg;
                end
                key_next   = sum_tmp[MW-1:0];
                put_next   = 1'b0;
                state_next = S_HASH;
            end
            S_DONE: begin
                mval_next = 1'b1;
                if (best_reg >= BW'(count_reg)) begin
                    mdat_next = '{found: 1'b0, removal_length: '0, overflow: 1'b0};
                end else begin
                    mdat_next = '{found: 1'b1,
                                  removal_length: best_reg[srm_pkg::LEN_W-1:0],
                                  overflow: 1'b0};
                end
                count_next = '0;
                state_next = S_LOAD;
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            mval_reg  <= mval_next;
        end
        idx_reg    <= idx_next;
        total_reg  <= total_next;
        prefix_reg <= prefix_next;
        key_reg    <= key_next;
        put_reg    <= put_next;
        slot_reg   <= slot_next;
        probe_reg  <= probe_next;
        best_reg   <= best_next;
        mdat_reg   <= mdat_next;
    end

    assign m_valid = mval_reg;
    assign m_data  = mdat_reg;

    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_LOAD) |-> !s_ready)
        else $error("request taken while solving");

    a_ovf_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (mval_reg && mdat_reg.overflow) |-> !mdat_reg.found)
        else $error("overflowed set reported a removal");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_RWAIT))
        else $error("residue result outside residue pass");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_LOAD) |-> (idx_reg <= count_reg))
        else $error("scan index past set size");

endmodule
